>>> hdl/btrf_pkg.sv
// Shared types and constants for the block trace record filter.
// Depends on nothing; every other file in hdl imports it.
package btrf_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [31:0] MAGIC_VALUE   = 32'h6561_7400;
    localparam logic [31:0] MAGIC_MASK    = 32'hFFFF_FF00;
    localparam logic [7:0]  VERSION_VALUE = 8'h07;
    localparam int unsigned ACT_SHIFT     = 16;
    localparam int unsigned ACT_READ_BIT  = ACT_SHIFT + 0;
    localparam int unsigned ACT_WRITE_BIT = ACT_SHIFT + 1;

    localparam int unsigned MODE_CPU_BIT   = 0;
    localparam int unsigned MODE_PID_BIT   = 1;
    localparam int unsigned MODE_DELTA_BIT = 2;

    localparam int unsigned IN_DATA_W  = 288;
    localparam int unsigned OUT_DATA_W = 200;
    localparam int unsigned OUT_USER_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SKIP_COUNT   = 3'd0,
        REG_RECORD_LIMIT = 3'd1,
        REG_LBA_LOW      = 3'd2,
        REG_LBA_HIGH     = 3'd3,
        REG_PID_MATCH    = 3'd4,
        REG_CPU_MATCH    = 3'd5,
        REG_FILTER_MODE  = 3'd6
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_KEPT     = 3'd0,
        ST_FILTERED = 3'd1,
        ST_BAD      = 3'd2,
        ST_END      = 3'd3,
        ST_ERROR    = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] skip_count;
        logic [31:0] record_limit;
        logic [63:0] lba_low;
        logic [63:0] lba_high;
        logic [31:0] pid_match;
        logic [31:0] cpu_match;
        logic [2:0]  filter_mode;
    } cfg_t;

    typedef struct packed {
        logic [31:0] cpu_number;
        logic [31:0] process_id;
        logic [31:0] action_bits;
        logic [31:0] byte_count;
        logic [63:0] start_sector;
        logic [63:0] timestamp;
        logic [31:0] magic_word;
    } record_t;

    typedef struct packed {
        status_t     status;
        logic        is_write;
        logic [63:0] time_delta;
        logic [63:0] length_or_delta;
        logic [63:0] record_sector;
    } result_t;

endpackage

>>> hdl/block_trace_record_filter_top.sv
// Block trace record filter, top level. Depends on btrf_pkg, btrf_cfg, btrf_eval.
// Requests pass the input register, then the result register; throughput one
// request per cycle unless m_axis_tready stalls the output, set by the single
// decision stage between the two registers. Reset (rst_n, async, active low)
// clears both stages, the stream state and restores register defaults.
module block_trace_record_filter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [btrf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [btrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // magic_word, timestamp, start_sector, byte_count, action_bits,
    // process_id, cpu_number (lowest bit up)
    input  logic [btrf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // record_sector, length_or_delta, time_delta, is_write, zero pad
    output logic [btrf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [btrf_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import btrf_pkg::*;

    cfg_t    cfg;
    record_t rec_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    in_take;
    logic    fire;

    // Advance the held request into the result register whenever that
    // register is empty or its content is being taken this cycle.
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    btrf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    btrf_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rec   (rec_reg),
        .fire  (fire),
        .res   (res)
    );

    // Input stage: hold one request; payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rec_reg <= record_t'(s_axis_tdata);
        end
    end

    // Result stage: load on fire, drop the valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.is_write, out_reg.time_delta,
                            out_reg.length_or_delta, out_reg.record_sector};
    assign m_axis_tuser  = out_reg.status;

endmodule

>>> hdl/btrf_cfg.sv
// Configuration register file for the block trace record filter.
// Depends on btrf_pkg for the register index codes and the cfg_t struct.
module btrf_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [btrf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [btrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output btrf_pkg::cfg_t                  cfg
);
    import btrf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_addr))
                REG_SKIP_COUNT:   cfg_next.skip_count   = cfg_wdata[31:0];
                REG_RECORD_LIMIT: cfg_next.record_limit = cfg_wdata[31:0];
                REG_LBA_LOW:      cfg_next.lba_low      = cfg_wdata;
                REG_LBA_HIGH:     cfg_next.lba_high     = cfg_wdata;
                REG_PID_MATCH:    cfg_next.pid_match    = cfg_wdata[31:0];
                REG_CPU_MATCH:    cfg_next.cpu_match    = cfg_wdata[31:0];
                REG_FILTER_MODE:  cfg_next.filter_mode  = cfg_wdata[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_count   <= '0;
            cfg_reg.record_limit <= '1;
            cfg_reg.lba_low      <= '0;
            cfg_reg.lba_high     <= '1;
            cfg_reg.pid_match    <= '0;
            cfg_reg.cpu_match    <= '0;
            cfg_reg.filter_mode  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/btrf_eval.sv
// Per-record decision logic and the running stream state (position,
// sticky flags, last kept sector and time). Depends on btrf_pkg.
module btrf_eval (
    input  logic              clk,
    input  logic              rst_n,
    input  btrf_pkg::cfg_t    cfg,
    input  btrf_pkg::record_t rec,
    input  logic              fire,
    output btrf_pkg::result_t res
);
    import btrf_pkg::*;

    logic [31:0] position_count_reg, position_count_next;
    logic        first_pending_reg, first_pending_next;
    logic [63:0] previous_sector_reg, previous_sector_next;
    logic [63:0] previous_time_reg, previous_time_next;
    logic        error_flag_reg, error_flag_next;
    logic        end_flag_reg, end_flag_next;

    logic        magic_ok;
    logic [31:0] pos_inc;
    logic        rd;
    logic        wr;
    logic        cpu_miss;
    logic        pid_miss;
    logic        window_miss;
    logic        kind_miss;
    logic        use_prev;

    assign magic_ok = ((rec.magic_word & MAGIC_MASK) == MAGIC_VALUE)
                   && (rec.magic_word[7:0] == VERSION_VALUE);
    assign pos_inc  = (position_count_reg == '1) ? position_count_reg
                                                 : position_count_reg + 32'd1;
    assign rd       = rec.action_bits[ACT_READ_BIT];
    assign wr       = rec.action_bits[ACT_WRITE_BIT];
    assign cpu_miss = cfg.filter_mode[MODE_CPU_BIT] && (rec.cpu_number != cfg.cpu_match);
    assign pid_miss = cfg.filter_mode[MODE_PID_BIT] && (rec.process_id != cfg.pid_match);
    assign window_miss = (rec.start_sector < cfg.lba_low) || (rec.start_sector > cfg.lba_high);
    assign kind_miss   = (!wr && !rd) || (rec.byte_count == '0);
    assign use_prev    = !first_pending_reg && (rec.start_sector >= previous_sector_reg);

    always_comb
    begin
        res                  = '0;
        res.status           = ST_FILTERED;
        position_count_next  = position_count_reg;
        first_pending_next   = first_pending_reg;
        previous_sector_next = previous_sector_reg;
        previous_time_next   = previous_time_reg;
        error_flag_next      = error_flag_reg;
        end_flag_next        = end_flag_reg;

        if (error_flag_reg)
        begin
            res.status = ST_ERROR;
        end
        else if (end_flag_reg)
        begin
            res.status = ST_END;
        end
        else if (!magic_ok)
        begin
            res.status      = ST_BAD;
            error_flag_next = 1'b1;
        end
        else
        begin
            position_count_next = pos_inc;
            if (pos_inc < cfg.skip_count)
            begin
                res.status = ST_FILTERED;
            end
            else if (pos_inc > cfg.record_limit)
            begin
                res.status    = ST_END;
                end_flag_next = 1'b1;
            end
            else if (cpu_miss || pid_miss || window_miss || kind_miss)
            begin
                res.status = ST_FILTERED;
            end
            else
            begin
                res.status        = ST_KEPT;
                res.record_sector = rec.start_sector;
                if (cfg.filter_mode[MODE_DELTA_BIT])
                begin
                    res.length_or_delta = use_prev
                        ? rec.start_sector - previous_sector_reg
                        : rec.start_sector - cfg.lba_low;
                end
                else
                begin
                    res.length_or_delta = {32'd0, rec.byte_count};
                end
                res.time_delta = first_pending_reg ? 64'd0
                                                   : rec.timestamp - previous_time_reg;
                // read wins when both direction bits are set
                res.is_write         = !rd;
                first_pending_next   = 1'b0;
                previous_sector_next = rec.start_sector;
                previous_time_next   = rec.timestamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_count_reg  <= '0;
            first_pending_reg   <= 1'b1;
            previous_sector_reg <= '0;
            previous_time_reg   <= '0;
            error_flag_reg      <= 1'b0;
            end_flag_reg        <= 1'b0;
        end
        else if (fire)
        begin
            position_count_reg  <= position_count_next;
            first_pending_reg   <= first_pending_next;
            previous_sector_reg <= previous_sector_next;
            previous_time_reg   <= previous_time_next;
            error_flag_reg      <= error_flag_next;
            end_flag_reg        <= end_flag_next;
        end
    end

endmodule
